// File: rtl/u8sd_pkg.sv
// Shared types and codes for the UTF-8 stream decoder controller and datapath.
package u8sd_pkg;

    // Classification of a byte handed to the datapath
    localparam logic [2:0] KIND_HOLD      = 3'd0;  // state update, no result
    localparam logic [2:0] KIND_ONE       = 3'd1;  // exactly one result now
    localparam logic [2:0] KIND_REJ_EOT   = 3'd2;  // sequence cut off by end of text
    localparam logic [2:0] KIND_REJ_VAL   = 3'd3;  // complete but unacceptable value
    localparam logic [2:0] KIND_REJ_FRESH = 3'd4;  // non-continuation while pending

    // Datapath operations
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_ACCEPT    = 3'd1;  // take a new byte from the port
    localparam logic [2:0] OP_EMIT_LEAD = 3'd2;  // emit negated lead byte
    localparam logic [2:0] OP_EMIT_BUF  = 3'd3;  // emit next negated buffered byte
    localparam logic [2:0] OP_EMIT_B    = 3'd4;  // emit negated held byte
    localparam logic [2:0] OP_FRESH     = 3'd5;  // reprocess held byte as a lead

    typedef struct packed {
        logic [2:0] op;
        logic       last;   // last result of this request
        logic       clear;  // drop the pending sequence
    } u8sd_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       cnt_zero;     // no continuation buffered
        logic       idx_last;     // replay index at last buffered byte
        logic       fresh_emits;  // held byte gives a result when reprocessed
        logic       out_free;     // output register can take a result
    } u8sd_status_t;

endpackage

// File: rtl/u8sd_datapath.sv
// Datapath: sequence state, continuation buffer, value checks and output register.
module u8sd_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          byte_req,
    input  logic                end_of_text,
    input  u8sd_pkg::u8sd_cmd_t cmd,
    output u8sd_pkg::u8sd_status_t status,
    output logic                rune_valid,
    input  logic                rune_stall,
    output logic signed [21:0]  rune,
    output logic                malformed,
    output logic                last_of_run
);

    localparam logic [30:0] MAX_RUNE  = 31'h10ffff;
    localparam logic [30:0] NC_LO     = 31'h00fdd0;
    localparam logic [30:0] NC_HI     = 31'h00fdef;
    localparam logic [15:0] NC_FE     = 16'hfffe;
    localparam logic [15:0] NC_FF     = 16'hffff;
    localparam logic [30:0] PU0_LO    = 31'h00e000;
    localparam logic [30:0] PU0_HI    = 31'h00f8ff;
    localparam logic [30:0] PU1_LO    = 31'h0f0000;
    localparam logic [30:0] PU1_HI    = 31'h0ffffd;
    localparam logic [30:0] PU2_LO    = 31'h100000;
    localparam logic [30:0] PU2_HI    = 31'h10fffd;
    localparam logic [30:0] SURR_LO   = 31'h00d800;
    localparam logic [30:0] SURR_HI   = 31'h00dfff;

    // Shortest-form length, range and class checks on a completed value
    function automatic logic value_ok(input logic [30:0] v, input logic [2:0] n);
        logic [2:0] need;
        logic       ok;
        need = 3'd1;
        if (v >= 31'h80)      need = 3'd2;
        if (v >= 31'h800)     need = 3'd3;
        if (v >= 31'h10000)   need = 3'd4;
        if (v >= 31'h200000)  need = 3'd5;
        if (v >= 31'h4000000) need = 3'd6;
        ok = (need == n);
        if (v > MAX_RUNE) ok = 1'b0;
        if (v >= NC_LO && v <= NC_HI) ok = 1'b0;
        if (v[15:0] == NC_FE || v[15:0] == NC_FF) ok = 1'b0;
        if (v >= PU0_LO && v <= PU0_HI) ok = 1'b0;
        if (v >= PU1_LO && v <= PU1_HI) ok = 1'b0;
        if (v >= PU2_LO && v <= PU2_HI) ok = 1'b0;
        if (v >= SURR_LO && v <= SURR_HI) ok = 1'b0;
        return ok;
    endfunction

    // Sequence state
    logic [7:0]  lead_reg, lead_next;
    logic [2:0]  len_reg, len_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [30:0] acc_reg, acc_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  cont_reg [4];
    logic [7:0]  byte_reg;
    logic        eot_reg;

    // Output register
    logic               valid_reg, valid_next;
    logic signed [21:0] rune_reg, rune_next;
    logic               mal_reg, mal_next;
    logic               last_reg, last_next;

    // Byte processing
    logic        is_proc;
    logic [7:0]  proc_byte;
    logic        proc_eot;
    logic        proc_pend;
    logic [30:0] acc_shift;
    logic [2:0]  cnt_inc;
    logic [2:0]  lead_len;
    logic [6:0]  lead_mask;
    logic [2:0]  kind;
    logic [21:0] proc_rune;
    logic        proc_mal;
    logic        cont_wr;
    logic        lead_ld;
    logic        emit;
    logic        out_free;

    assign out_free = !valid_reg || !rune_stall;

    // Classify the byte being processed
    always_comb
    begin
        is_proc   = (cmd.op == u8sd_pkg::OP_ACCEPT) || (cmd.op == u8sd_pkg::OP_FRESH);
        proc_byte = (cmd.op == u8sd_pkg::OP_ACCEPT) ? byte_req : byte_reg;
        proc_eot  = (cmd.op == u8sd_pkg::OP_ACCEPT) ? end_of_text : eot_reg;
        proc_pend = (cmd.op == u8sd_pkg::OP_ACCEPT) && (len_reg != 3'd0);
        acc_shift = {acc_reg[24:0], proc_byte[5:0]};
        cnt_inc   = cnt_reg + 3'd1;

        priority if (proc_byte < 8'he0)
            lead_len = 3'd2;
        else if (proc_byte < 8'hf0)
            lead_len = 3'd3;
        else if (proc_byte < 8'hf8)
            lead_len = 3'd4;
        else if (proc_byte < 8'hfc)
            lead_len = 3'd5;
        else
            lead_len = 3'd6;
        lead_mask = 7'h7f >> lead_len;

        kind      = u8sd_pkg::KIND_ONE;
        proc_rune = 22'd0 - {14'd0, proc_byte};
        proc_mal  = 1'b1;
        cont_wr   = 1'b0;
        lead_ld   = 1'b0;
        if (!proc_pend)
        begin
            if (proc_byte < 8'h80)
            begin
                proc_rune = {14'd0, proc_byte};
                proc_mal  = 1'b0;
            end
            else if (proc_byte >= 8'hc0 && proc_byte < 8'hfe && !proc_eot)
            begin
                kind    = u8sd_pkg::KIND_HOLD;
                lead_ld = 1'b1;
            end
        end
        else if (proc_byte[7:6] != 2'b10)
            kind = u8sd_pkg::KIND_REJ_FRESH;
        else if ({1'b0, cnt_reg} + 4'd2 >= {1'b0, len_reg})
        begin
            if (value_ok(acc_shift, len_reg))
            begin
                proc_rune = acc_shift[21:0];
                proc_mal  = 1'b0;
            end
            else
                kind = u8sd_pkg::KIND_REJ_VAL;
        end
        else
        begin
            cont_wr = 1'b1;
            kind    = proc_eot ? u8sd_pkg::KIND_REJ_EOT : u8sd_pkg::KIND_HOLD;
        end
    end

    // Next sequence state and output register
    always_comb
    begin
        lead_next  = lead_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        rune_next  = rune_reg;
        mal_next   = mal_reg;
        last_next  = last_reg;

        unique case (cmd.op)
            u8sd_pkg::OP_ACCEPT, u8sd_pkg::OP_FRESH:
            begin
                idx_next = 2'd0;
                if (kind == u8sd_pkg::KIND_ONE)
                begin
                    emit      = 1'b1;
                    rune_next = proc_rune;
                    mal_next  = proc_mal;
                    last_next = 1'b1;
                    lead_next = 8'd0;
                    len_next  = 3'd0;
                    cnt_next  = 3'd0;
                    acc_next  = 31'd0;
                end
                else if (lead_ld)
                begin
                    lead_next = proc_byte;
                    len_next  = lead_len;
                    cnt_next  = 3'd0;
                    acc_next  = {24'd0, proc_byte[6:0] & lead_mask};
                end
                else if (cont_wr)
                begin
                    cnt_next = cnt_inc;
                    acc_next = acc_shift;
                end
            end
            u8sd_pkg::OP_EMIT_LEAD:
            begin
                emit      = 1'b1;
                rune_next = 22'd0 - {14'd0, lead_reg};
                mal_next  = 1'b1;
                last_next = cmd.last;
            end
            u8sd_pkg::OP_EMIT_BUF:
            begin
                emit      = 1'b1;
                rune_next = 22'd0 - {14'd0, cont_reg[idx_reg]};
                mal_next  = 1'b1;
                last_next = cmd.last;
                idx_next  = idx_reg + 2'd1;
            end
            u8sd_pkg::OP_EMIT_B:
            begin
                emit      = 1'b1;
                rune_next = 22'd0 - {14'd0, byte_reg};
                mal_next  = 1'b1;
                last_next = cmd.last;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Replay finished: the pending sequence is gone
        if (cmd.clear)
        begin
            lead_next = 8'd0;
            len_next  = 3'd0;
            cnt_next  = 3'd0;
            acc_next  = 31'd0;
        end

        if (emit)
            valid_next = 1'b1;
        else if (out_free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg  <= 8'd0;
            len_reg   <= 3'd0;
            cnt_reg   <= 3'd0;
            acc_reg   <= 31'd0;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            lead_reg  <= lead_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers and continuation buffer
    always_ff @(posedge clk)
    begin
        rune_reg <= rune_next;
        mal_reg  <= mal_next;
        last_reg <= last_next;
        if (cmd.op == u8sd_pkg::OP_ACCEPT)
        begin
            byte_reg <= byte_req;
            eot_reg  <= end_of_text;
        end
        if (is_proc && cont_wr)
            cont_reg[cnt_reg[1:0]] <= proc_byte;
    end

    // Status toward the controller
    always_comb
    begin
        status.kind        = kind;
        status.cnt_zero    = (cnt_reg == 3'd0);
        status.idx_last    = ({1'b0, idx_reg} + 3'd1 == cnt_reg);
        status.fresh_emits = (byte_reg < 8'hc0) || (byte_reg >= 8'hfe) || eot_reg;
        status.out_free    = out_free;
    end

    assign rune_valid  = valid_reg;
    assign rune        = rune_reg;
    assign malformed   = mal_reg;
    assign last_of_run = last_reg;

endmodule

// File: rtl/u8sd_ctrl.sv
// Controller: accepts bytes and sequences the replay of rejected sequences.
module u8sd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  u8sd_pkg::u8sd_status_t status,
    output u8sd_pkg::u8sd_cmd_t    cmd
);

    localparam logic [2:0] S_ACCEPT = 3'd0;
    localparam logic [2:0] S_LEAD   = 3'd1;
    localparam logic [2:0] S_BUF    = 3'd2;
    localparam logic [2:0] S_NEGB   = 3'd3;
    localparam logic [2:0] S_FRESH  = 3'd4;

    // What follows the replay of lead and buffered bytes
    localparam logic [1:0] F_NONE  = 2'd0;
    localparam logic [1:0] F_NEGB  = 2'd1;
    localparam logic [1:0] F_FRESH = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] follow_reg, follow_next;
    logic [2:0] after_rej;
    logic       tail_empty;

    always_comb
    begin
        tail_empty = (follow_reg == F_NONE) ||
                     ((follow_reg == F_FRESH) && !status.fresh_emits);
        unique case (follow_reg)
            F_NEGB:  after_rej = S_NEGB;
            F_FRESH: after_rej = S_FRESH;
            default: after_rej = S_ACCEPT;
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        follow_next = follow_reg;
        cmd.op      = u8sd_pkg::OP_NONE;
        cmd.last    = 1'b0;
        cmd.clear   = 1'b0;
        byte_stall  = 1'b1;

        unique case (state_reg)
            S_ACCEPT:
            begin
                byte_stall = !status.out_free;
                if (byte_valid && status.out_free)
                begin
                    cmd.op = u8sd_pkg::OP_ACCEPT;
                    unique case (status.kind)
                        u8sd_pkg::KIND_REJ_EOT:
                        begin
                            follow_next = F_NONE;
                            state_next  = S_LEAD;
                        end
                        u8sd_pkg::KIND_REJ_VAL:
                        begin
                            follow_next = F_NEGB;
                            state_next  = S_LEAD;
                        end
                        u8sd_pkg::KIND_REJ_FRESH:
                        begin
                            follow_next = F_FRESH;
                            state_next  = S_LEAD;
                        end
                        default:
                        begin
                            state_next = S_ACCEPT;
                        end
                    endcase
                end
            end
            S_LEAD:
            begin
                if (status.out_free)
                begin
                    cmd.op     = u8sd_pkg::OP_EMIT_LEAD;
                    cmd.last   = status.cnt_zero && tail_empty;
                    cmd.clear  = status.cnt_zero;
                    state_next = status.cnt_zero ? after_rej : S_BUF;
                end
            end
            S_BUF:
            begin
                if (status.out_free)
                begin
                    cmd.op    = u8sd_pkg::OP_EMIT_BUF;
                    cmd.last  = status.idx_last && tail_empty;
                    cmd.clear = status.idx_last;
                    if (status.idx_last)
                        state_next = after_rej;
                end
            end
            S_NEGB:
            begin
                if (status.out_free)
                begin
                    cmd.op     = u8sd_pkg::OP_EMIT_B;
                    cmd.last   = 1'b1;
                    state_next = S_ACCEPT;
                end
            end
            S_FRESH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = u8sd_pkg::OP_FRESH;
                    state_next = S_ACCEPT;
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_ACCEPT;
            follow_reg <= F_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            follow_reg <= follow_next;
        end
    end

endmodule

// File: rtl/utf8_stream_decoder_core.sv
// A byte that gives a single result shows it on the output register in the cycle after it
// is accepted. Throughput: one byte per cycle while the output is free, for valid text
// and for bytes that give one or no result. A rejected sequence replays one negated byte
// per cycle through the output register while it is free, so input is held for the replay
// and for reprocessing a byte that opens a new sequence and so gives no result of its own.
// Reset (rst_n low, asynchronous) clears the controller, sequence state and output valid;
// the continuation buffer is not cleared and is only read after being written.
module utf8_stream_decoder_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         byte_req,
    input  logic               end_of_text,
    output logic               rune_valid,
    input  logic               rune_stall,
    output logic signed [21:0] rune,
    output logic               malformed,
    output logic               last_of_run
);

    u8sd_pkg::u8sd_cmd_t    cmd;
    u8sd_pkg::u8sd_status_t status;

    u8sd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .status     (status),
        .cmd        (cmd)
    );

    u8sd_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_req    (byte_req),
        .end_of_text (end_of_text),
        .cmd         (cmd),
        .status      (status),
        .rune_valid  (rune_valid),
        .rune_stall  (rune_stall),
        .rune        (rune),
        .malformed   (malformed),
        .last_of_run (last_of_run)
    );

endmodule

// File: rtl/u8sd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module u8sd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               byte_valid,
    input logic               byte_stall,
    input logic [7:0]         byte_req,
    input logic               end_of_text,
    input logic               rune_valid,
    input logic               rune_stall,
    input logic signed [21:0] rune,
    input logic               malformed,
    input logic               last_of_run
);

    // Rejected bytes are always negative
    a_mal_negative: assert property (@(posedge clk) disable iff (!rst_n)
        rune_valid && malformed |-> rune[21])
        else $error("malformed result is not negative");

    // Decoded code points are never negative
    a_ok_positive: assert property (@(posedge clk) disable iff (!rst_n)
        rune_valid && !malformed |-> !rune[21])
        else $error("decoded code point is negative");

    // No byte taken while a result sits stalled in the output register
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rune_valid && rune_stall |-> byte_stall)
        else $error("byte accepted while output stalled");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rune_valid && rune_stall |=> rune_valid && $stable(rune) &&
                                     $stable(malformed) && $stable(last_of_run))
        else $error("stalled result changed");

    // A stalled byte request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_req) &&
                                     $stable(end_of_text))
        else $error("stalled byte request changed");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_u8sd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_req    (byte_req),
    .end_of_text (end_of_text),
    .rune_valid  (rune_valid),
    .rune_stall  (rune_stall),
    .rune        (rune),
    .malformed   (malformed),
    .last_of_run (last_of_run)
);

// File: tb/utf8_stream_decoder_core_tb.sv
// Self-checking testbench for the UTF-8 stream decoder core.
module utf8_stream_decoder_core_tb;

    localparam int RANDOM_BYTES = 320;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;

    // One byte request as queued for the driver
    typedef struct {
        logic [7:0] b;
        logic       eot;
        int         phase;      // 0: both idle, 1: roles swapped, 2: no idling
        bit         drain;      // wait for all runes before offering this byte
        bit         long_hold;  // receiver holds off once this byte is offered
    } text_byte_t;

    // One expected rune
    typedef struct {
        logic signed [21:0] rune;
        logic               malformed;
        logic               last;
    } rune_res_t;

    logic               clk;
    logic               rst_n;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    logic [7:0]         byte_req = 8'h00;
    logic               end_of_text = 1'b0;
    logic               rune_valid;
    logic               rune_stall = 1'b0;
    logic signed [21:0] rune;
    logic               malformed;
    logic               last_of_run;

    text_byte_t text_bytes[$];
    text_byte_t cur_req;
    rune_res_t  expected_runes[$];
    rune_res_t  step_runes[$];

    // decoder state mirrored by the predictor
    logic [7:0]  dec_lead;
    logic [2:0]  dec_len;
    logic [2:0]  dec_cnt;
    logic [30:0] dec_acc;
    logic [7:0]  dec_buf[4];

    int  gen_phase;
    bit  next_drain;
    bit  next_hold;
    int  run_phase = 0;
    logic hold_kick = 1'b0;
    int  hold_left = 0;
    int  cycle_cnt = 0;
    int  err_cnt = 0;
    int  bytes_sent = 0;
    int  runes_seen = 0;
    int  bad_seen = 0;

    utf8_stream_decoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_req    (byte_req),
        .end_of_text (end_of_text),
        .rune_valid  (rune_valid),
        .rune_stall  (rune_stall),
        .rune        (rune),
        .malformed   (malformed),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void add_rune(logic [21:0] r, logic bad);
        rune_res_t res;
        res.rune      = r;
        res.malformed = bad;
        res.last      = 1'b0;
        step_runes.push_back(res);
    endfunction

    function automatic void add_negated(logic [7:0] b);
        add_rune(22'(-int'(b)), 1'b1);
    endfunction

    function automatic void seq_idle();
        dec_len  = 3'd0;
        dec_cnt  = 3'd0;
        dec_acc  = 31'd0;
        dec_lead = 8'h00;
    endfunction

    // Drop the pending sequence: negated lead, then buffered continuations
    function automatic void seq_flush();
        int cnt;
        cnt = (dec_cnt > 3'd4) ? 4 : int'(dec_cnt);
        add_negated(dec_lead);
        for (int i = 0; i < cnt; i++)
            add_negated(dec_buf[2'(i)]);
        seq_idle();
    endfunction

    function automatic bit code_ok(logic [30:0] v, int n);
        int unsigned vv;
        int need;
        vv = 32'(v);
        need = 1;
        if (vv >= 32'h80) need = 2;
        if (vv >= 32'h800) need = 3;
        if (vv >= 32'h10000) need = 4;
        if (vv >= 32'h200000) need = 5;
        if (vv >= 32'h4000000) need = 6;
        if (need != n) return 1'b0;
        if (vv > 32'h10FFFF) return 1'b0;
        if (vv >= 32'hFDD0 && vv <= 32'hFDEF) return 1'b0;
        if (vv[15:0] == 16'hFFFE || vv[15:0] == 16'hFFFF) return 1'b0;
        if (vv >= 32'hE000 && vv <= 32'hF8FF) return 1'b0;
        if (vv >= 32'hF0000 && vv <= 32'hFFFFD) return 1'b0;
        if (vv >= 32'h100000 && vv <= 32'h10FFFD) return 1'b0;
        if (vv >= 32'hD800 && vv <= 32'hDFFF) return 1'b0;
        return 1'b1;
    endfunction

    // Byte seen with no sequence pending
    function automatic void lead_byte_in(logic [7:0] b, logic eot);
        int n;
        if (b < 8'h80)
        begin
            add_rune(22'(b), 1'b0);
            return;
        end
        if (b < 8'hC0 || b >= 8'hFE)
        begin
            add_negated(b);
            return;
        end
        if (b < 8'hE0) n = 2;
        else if (b < 8'hF0) n = 3;
        else if (b < 8'hF8) n = 4;
        else if (b < 8'hFC) n = 5;
        else n = 6;
        dec_lead = b;
        dec_len  = 3'(n);
        dec_cnt  = 3'd0;
        dec_acc  = 31'(b) & ((31'd1 << (7 - n)) - 31'd1);
        if (eot)
            seq_flush();
    endfunction

    // Work out the runes caused by one accepted byte request
    function automatic void decode_byte(logic [7:0] b, logic eot);
        if (dec_len == 3'd0)
            lead_byte_in(b, eot);
        else if (b[7:6] != 2'b10)
        begin
            seq_flush();
            lead_byte_in(b, eot);
        end
        else
        begin
            dec_acc = {dec_acc[24:0], b[5:0]};
            dec_cnt = dec_cnt + 3'd1;
            if (int'(dec_cnt) + 1 >= int'(dec_len))
            begin
                if (code_ok(dec_acc, int'(dec_len)))
                begin
                    add_rune(dec_acc[21:0], 1'b0);
                    seq_idle();
                end
                else
                begin
                    dec_cnt = dec_cnt - 3'd1;
                    seq_flush();
                    add_negated(b);
                end
            end
            else
            begin
                dec_buf[2'(dec_cnt - 3'd1)] = b;
                if (eot)
                    seq_flush();
            end
        end
        if (step_runes.size() != 0)
            step_runes[step_runes.size() - 1].last = 1'b1;
        foreach (step_runes[i])
            expected_runes.push_back(step_runes[i]);
        step_runes.delete();
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void add_byte(logic [7:0] b, logic eot);
        text_byte_t t;
        t.b         = b;
        t.eot       = eot;
        t.phase     = gen_phase;
        t.drain     = next_drain;
        t.long_hold = next_hold;
        next_drain  = 1'b0;
        next_hold   = 1'b0;
        text_bytes.push_back(t);
    endfunction

    function automatic int min_len(int unsigned v);
        if (v < 32'h80) return 1;
        if (v < 32'h800) return 2;
        if (v < 32'h10000) return 3;
        if (v < 32'h200000) return 4;
        if (v < 32'h4000000) return 5;
        return 6;
    endfunction

    // Encode v in n bytes (overlong if n is too big), keeping the first keep bytes
    function automatic void add_code(int unsigned v, int n, int keep, bit eot_tail);
        logic [7:0] seq[6];
        logic [7:0] prefix;
        if (n == 1)
            seq[0] = {1'b0, v[6:0]};
        else
        begin
            prefix = 8'hFF << (8 - n);
            seq[0] = prefix | 8'((v >> (6 * (n - 1))) & ((32'd1 << (7 - n)) - 1));
            for (int i = 1; i < n; i++)
                seq[i] = 8'h80 | 8'((v >> (6 * (n - 1 - i))) & 32'h3F);
        end
        for (int i = 0; i < keep; i++)
            add_byte(seq[i], eot_tail && (i == keep - 1));
    endfunction

    function automatic int unsigned rand_code();
        case ($urandom_range(3))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            default: return $urandom_range(32'h10FFFF, 32'h10000);
        endcase
    endfunction

    function automatic void build_stimulus();
        int unsigned edge_vals[24] = '{32'hD7FF, 32'hD800, 32'hDFFF, 32'hE000, 32'hF8FF,
            32'hF900, 32'hFDCF, 32'hFDD0, 32'hFDEF, 32'hFDF0, 32'hFFFD, 32'hFFFE,
            32'hFFFF, 32'h10000, 32'h1FFFE, 32'hEFFFF, 32'hF0000, 32'hFFFFD, 32'hFFFFE,
            32'h100000, 32'h10FFFD, 32'h10FFFE, 32'h10FFFF, 32'h110000};
        int unsigned lens_lim[5] = '{32'h80, 32'h800, 32'h10000, 32'h200000, 32'h4000000};
        int unsigned v;
        int n;
        int r;
        int total;
        logic [7:0] b;
        bit eot_tail;

        gen_phase  = 0;
        next_drain = 1'b0;
        next_hold  = 1'b0;

        // directed: field extremes, invalid leads, overlong, surrogate, broken and cut-off sequences
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h80, 1'b0);                   // stray continuation
        add_byte(8'hBF, 1'b0);
        add_byte(8'hFE, 1'b0);                   // invalid leads
        add_byte(8'hFF, 1'b0);
        add_code(32'h80, 2, 2, 1'b0);            // smallest two-byte form
        add_code(32'h1F600, 4, 4, 1'b0);         // plain four-byte form
        add_code(32'h0, 2, 2, 1'b0);             // overlong
        add_code(32'hD800, 3, 3, 1'b0);          // surrogate
        add_code(32'h20AC, 3, 2, 1'b0);          // bad continuation follows
        add_byte(8'h41, 1'b0);
        add_code(32'h200000, 5, 5, 1'b0);        // five-byte forms always reject
        add_code(32'h20AC, 3, 2, 1'b1);          // cut off by end of text
        add_byte(8'hC3, 1'b1);                   // lead alone at end of text
        total = text_bytes.size() + RANDOM_BYTES;

        // random: well-formed sequences mixed with broken ones and noise
        while (text_bytes.size() < total)
        begin
            if (gen_phase == 0 && text_bytes.size() > total / 3)
            begin
                gen_phase  = 1;
                next_drain = 1'b1;
            end
            else if (gen_phase == 1 && text_bytes.size() > (2 * total) / 3)
            begin
                gen_phase  = 2;
                next_drain = 1'b1;
                next_hold  = 1'b1;
            end
            r = $urandom_range(99);
            eot_tail = ($urandom_range(99) < 4);
            if (r < 45)
            begin
                v = rand_code();
                add_code(v, min_len(v), min_len(v), eot_tail);
            end
            else if (r < 55)
            begin
                v = edge_vals[$urandom_range(23)];
                add_code(v, min_len(v), min_len(v), eot_tail);
            end
            else if (r < 63)
            begin
                n = $urandom_range(6, 2);
                v = $urandom_range(lens_lim[n - 2] - 1);
                add_code(v, n, n, eot_tail);
            end
            else if (r < 70)
            begin
                n = $urandom_range(6, 5);
                v = (n == 5) ? ($urandom() & 32'h3FFFFFF) : ($urandom() & 32'h7FFFFFFF);
                add_code(v, n, n, eot_tail);
            end
            else if (r < 88)
            begin
                n = $urandom_range(6, 2);
                v = $urandom() & ((n == 6) ? 32'h7FFFFFFF : ((32'd1 << (5 * n + 1)) - 1));
                add_code(v, n, $urandom_range(n - 1, 1), eot_tail);
                if (r >= 82)
                begin
                    b = 8'($urandom_range(255));
                    if (b[7:6] == 2'b10)
                        b = b ^ 8'h40;
                    add_byte(b, 1'b0);
                end
            end
            else
                add_byte(8'($urandom_range(255)), eot_tail);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        err_cnt++;
    endtask

    // ---------------- driver ----------------

    // Offers byte requests from the queue; predicts each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid  <= 1'b0;
            byte_req    <= 8'h00;
            end_of_text <= 1'b0;
            hold_kick   <= 1'b0;
        end
        else
        begin
            bit load;
            bit kick;
            int idle_pct;
            load = 1'b0;
            kick = 1'b0;
            if (byte_valid && !byte_stall)
            begin
                decode_byte(cur_req.b, cur_req.eot);
                bytes_sent++;
            end
            if (!(byte_valid && byte_stall))
            begin
                if (text_bytes.size() != 0)
                begin
                    idle_pct = (text_bytes[0].phase == 0) ? 32 :
                               (text_bytes[0].phase == 1) ? 52 : 0;
                    if (text_bytes[0].drain)
                        load = !byte_valid && (expected_runes.size() == 0);
                    else
                        load = ($urandom_range(99) >= idle_pct);
                end
                if (load)
                begin
                    cur_req = text_bytes.pop_front();
                    byte_valid  <= 1'b1;
                    byte_req    <= cur_req.b;
                    end_of_text <= cur_req.eot;
                    run_phase   <= cur_req.phase;
                    kick = cur_req.long_hold;
                end
                else
                    byte_valid <= 1'b0;
            end
            hold_kick <= kick;
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ---------------- monitor ----------------

    // Checks each accepted rune against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rune_stall <= 1'b0;
        else
        begin
            rune_res_t want;
            if (rune_valid && !rune_stall)
            begin
                runes_seen++;
                if (malformed)
                    bad_seen++;
                if (expected_runes.size() == 0)
                    report_mismatch("unexpected rune", int'(rune), 0);
                else
                begin
                    want = expected_runes.pop_front();
                    if (rune !== want.rune)
                        report_mismatch("rune", int'(rune), int'(want.rune));
                    if (malformed !== want.malformed)
                        report_mismatch("malformed", int'(malformed), int'(want.malformed));
                    if (last_of_run !== want.last)
                        report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
                end
            end
            if (hold_left != 0)
                rune_stall <= 1'b1;
            else if (run_phase == 0)
                rune_stall <= ($urandom_range(99) < 52);
            else if (run_phase == 1)
                rune_stall <= ($urandom_range(99) < 32);
            else
                rune_stall <= 1'b0;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d runes outstanding",
                     cycle_cnt, expected_runes.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (text_bytes.size() != 0 || byte_valid || expected_runes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("summary: %0d bytes decoded into %0d runes, %0d of them malformed",
                 bytes_sent, runes_seen, bad_seen);
        $display("summary: %0d mismatches over %0d cycles", err_cnt, cycle_cnt);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
